// ===== rtl/tadr_pkg.sv =====
// ----------------------------------------------------------------------------
// tadr_pkg: shared types and constants for touch action debounce and repeat
// Holds stream widths, register indexes, action bit positions and the
// repeat-state encoding used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tadr_pkg;

  // Field widths
  localparam int unsigned ActW    = 21;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned InDataW = 56;  // 55 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 32; // 26 bits of fields, padded to bytes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxDebounce  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxRepDelay  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxRepRate   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxLightStep = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxLightMax  = 3'd4;

  // Register reset values
  localparam logic [MsW-1:0]    DebounceRst  = 16'd120;
  localparam logic [MsW-1:0]    RepDelayRst  = 16'd500;
  localparam logic [MsW-1:0]    RepRateRst   = 16'd150;
  localparam logic [LevelW-1:0] LightStepRst = 4'd1;
  localparam logic [LevelW-1:0] LightMaxRst  = 4'd10;

  // Action bit positions
  localparam int unsigned BitRefresh = 9;
  localparam int unsigned BitPrev    = 10;
  localparam int unsigned BitNext    = 11;
  localparam int unsigned BitLoff    = 16;
  localparam int unsigned BitLdown   = 17;
  localparam int unsigned BitLup     = 18;

  // Input kinds carried in tuser
  localparam logic OpSample     = 1'b0;
  localparam logic OpPageChange = 1'b1;

  typedef enum logic [1:0] {
    RepNone = 2'd0,
    RepPrev = 2'd1,
    RepNext = 2'd2
  } tadr_rep_e;

  // Fired light actions handed to the level stepper
  typedef struct packed {
    logic off;
    logic up;
    logic down;
  } tadr_light_t;

endpackage

`default_nettype wire

// ===== rtl/tadr_light.sv =====
// ----------------------------------------------------------------------------
// tadr_light: brightness level stepper
// Applies one fired light action to the level: off clears it, up adds the
// step and saturates at the maximum, down subtracts the step and floors at 0.
// ----------------------------------------------------------------------------
`default_nettype none

module tadr_light (
  input  tadr_pkg::tadr_light_t     act_i,
  input  logic [tadr_pkg::LevelW-1:0] level_i,
  input  logic [tadr_pkg::LevelW-1:0] step_i,
  input  logic [tadr_pkg::LevelW-1:0] max_i,
  output logic [tadr_pkg::LevelW-1:0] level_o
);
  import tadr_pkg::*;

  logic [LevelW:0] sum;

  assign sum = {1'b0, level_i} + {1'b0, step_i};

  // Off wins over up, up wins over down
  always_comb begin
    if (act_i.off) begin
      level_o = '0;
    end else if (act_i.up) begin
      level_o = (sum > {1'b0, max_i}) ? max_i : sum[LevelW-1:0];
    end else if (act_i.down) begin
      level_o = (level_i < step_i) ? '0 : level_i - step_i;
    end else begin
      level_o = level_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/touch_action_debounce_repeat_top.sv =====
// ----------------------------------------------------------------------------
// touch_action_debounce_repeat_top: touch action debounce with auto-repeat
// Debounces a raw action mask per action, auto-repeats a single held
// navigation action and steps a saturating brightness level.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / payload                        | tuser
//  s_axis   | in        | raw_actions, touched, on_battery_page,  | opcode
//           |           | now_ms                                  |
//  m_axis   | out       | fired_actions, brightness,              | -
//           |           | brightness_write                        |
//  cfg      | in        | cfg_index_i, cfg_data_i (always ready)  | -
//
//  One item per cycle sustained while the result side is ready. An item is
//  captured in the input register, is evaluated in one pass (21 parallel lockout
//  compares, repeat deadline compare, level stepper) and lands in the result
//  register. Reset restores the register defaults and clears the block state
//  and both valid flags at once. A stalled result holds; one further item
//  waits in the input register while the result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_action_debounce_repeat_top #(
  parameter int unsigned NUM_ACTIONS = 21
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [20:0] raw_actions, [21] touched, [22] on_battery_page, [54:23] now_ms
  input  logic [tadr_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] opcode
  input  logic [0:0]                        s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [20:0] fired_actions, [24:21] brightness, [25] brightness_write
  output logic [tadr_pkg::OutDataW-1:0]     m_axis_tdata,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tadr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tadr_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tadr_pkg::*;

  // Only the actions inside the 21-bit mask can ever fire
  localparam int unsigned NumLive = (NUM_ACTIONS < ActW) ? NUM_ACTIONS : ActW;

  // Configuration registers
  logic [MsW-1:0]    debounce_q, rep_delay_q, rep_rate_q;
  logic [LevelW-1:0] light_step_q, light_max_q;

  // Pipeline registers
  logic               in_valid_q;
  logic               in_op_q;
  logic [InDataW-1:0] in_data_q;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic               advance;

  // Block state
  logic [ActW-1:0]   prior_q, prior_d;
  logic [TimeW-1:0]  stamp_q [NumLive];
  logic              ignore_q, ignore_d;
  tadr_rep_e         rep_q, rep_d;
  logic [TimeW-1:0]  deadline_q, deadline_d;
  logic [LevelW-1:0] level_q, level_d;

  // Unpacked item fields
  logic [ActW-1:0]  raw;
  logic             touched;
  logic             battery;
  logic [TimeW-1:0] now;

  logic [1:0]       nav, held_nav;
  logic [ActW-1:0]  current;
  logic [ActW-1:0]  hit;
  logic [ActW-1:0]  fired;
  logic             do_normal;
  tadr_rep_e        code;
  logic [TimeW-1:0] dl_diff;
  logic             rep_fire;
  tadr_light_t      light_act;
  logic             light_any;
  logic [LevelW-1:0] level_step;
  logic [ActW-1:0]  fired_out;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceRst;
      rep_delay_q  <= RepDelayRst;
      rep_rate_q   <= RepRateRst;
      light_step_q <= LightStepRst;
      light_max_q  <= LightMaxRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxDebounce:  debounce_q   <= cfg_data_i;
        CfgIdxRepDelay:  rep_delay_q  <= cfg_data_i;
        CfgIdxRepRate:   rep_rate_q   <= cfg_data_i;
        CfgIdxLightStep: light_step_q <= cfg_data_i[LevelW-1:0];
        CfgIdxLightMax:  light_max_q  <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: advance the input register when the result register frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture item payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser[0];
      in_data_q <= s_axis_tdata;
    end
  end

  assign raw     = in_data_q[ActW-1:0];
  assign touched = in_data_q[ActW];
  assign battery = in_data_q[ActW+1];
  assign now     = in_data_q[ActW+2 +: TimeW];

  // Navigation counts as held only when exactly one of the two bits is set
  assign nav      = raw[BitNext:BitPrev];
  assign held_nav = (nav[0] ^ nav[1]) ? nav : 2'b00;
  always_comb begin
    current = raw;
    current[BitNext:BitPrev] = held_nav;
  end

  assign do_normal = (in_op_q == OpSample) && !ignore_q;

  // Per-action rising edge with lockout since its last edge firing
  for (genvar i = 0; i < ActW; i++) begin : g_hit
    if (i < NumLive) begin : g_live
      logic [TimeW-1:0] since;
      assign since  = now - stamp_q[i];
      assign hit[i] = current[i] && !prior_q[i] &&
                      (since >= {{(TimeW-MsW){1'b0}}, debounce_q});
    end else begin : g_dead
      assign hit[i] = 1'b0;
    end
  end

  // Repeat decision
  always_comb begin
    case (held_nav)
      2'b01:   code = RepPrev;
      2'b10:   code = RepNext;
      default: code = RepNone;
    endcase
  end

  assign dl_diff  = now - deadline_q;
  assign rep_fire = (code != RepNone) && (rep_q == code) && !dl_diff[TimeW-1];

  always_comb begin
    fired = hit;
    if (rep_fire) begin
      fired[BitNext:BitPrev] = fired[BitNext:BitPrev] | held_nav;
    end
  end

  // Light actions step the level
  assign light_act.off  = fired[BitLoff];
  assign light_act.up   = fired[BitLup];
  assign light_act.down = fired[BitLdown];
  assign light_any      = light_act.off || light_act.up || light_act.down;

  tadr_light u_light (
    .act_i   (light_act),
    .level_i (level_q),
    .step_i  (light_step_q),
    .max_i   (light_max_q),
    .level_o (level_step)
  );

  // Next state
  always_comb begin
    prior_d    = prior_q;
    ignore_d   = ignore_q;
    rep_d      = rep_q;
    deadline_d = deadline_q;
    level_d    = level_q;
    fired_out  = '0;
    if (in_op_q == OpPageChange) begin
      ignore_d   = 1'b1;
      rep_d      = RepNone;
      deadline_d = '0;
    end else if (ignore_q) begin
      rep_d      = RepNone;
      deadline_d = '0;
      prior_d    = touched ? current : '0;
      ignore_d   = touched;
    end else begin
      prior_d = current;
      if (code == RepNone) begin
        rep_d      = RepNone;
        deadline_d = '0;
      end else if (rep_q != code) begin
        rep_d      = code;
        deadline_d = now + {{(TimeW-MsW){1'b0}}, rep_delay_q};
      end else if (rep_fire) begin
        deadline_d = now + {{(TimeW-MsW){1'b0}}, rep_rate_q};
      end
      fired_out = fired;
      if (light_any) begin
        level_d = level_step;
        if (battery) begin
          fired_out[BitRefresh] = 1'b1;
        end
      end
      fired_out[BitLup:BitLoff] = 3'b000;
    end
  end

  // Commit state on each evaluated item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q    <= '0;
      ignore_q   <= 1'b0;
      rep_q      <= RepNone;
      deadline_q <= '0;
      level_q    <= '0;
    end else if (advance) begin
      prior_q    <= prior_d;
      ignore_q   <= ignore_d;
      rep_q      <= rep_d;
      deadline_q <= deadline_d;
      level_q    <= level_d;
    end
  end

  // Stamp each action that fired on its edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < NumLive; k++) begin
        stamp_q[k] <= '0;
      end
    end else if (advance && do_normal) begin
      for (int unsigned k = 0; k < NumLive; k++) begin
        if (hit[k]) begin
          stamp_q[k] <= now;
        end
      end
    end
  end

  // Load result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {{(OutDataW-ActW-LevelW-1){1'b0}},
                     do_normal && light_any, level_d, fired_out};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tadr_checker.sv =====
// ----------------------------------------------------------------------------
// tadr_checker: port-level checks for touch action debounce and repeat
// Watches the stream ports for result stability, item accounting and the
// brightness reporting rules; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tadr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [tadr_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [0:0]                    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tadr_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [tadr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [tadr_pkg::CfgDataW-1:0] cfg_data_i
);
  import tadr_pkg::*;

  logic              in_acc, out_acc;
  logic [1:0]        flight_q;
  logic [LevelW-1:0] last_level_q;
  logic [LevelW-1:0] out_level;
  logic              out_write;
  logic              unused_ok;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign out_level = m_axis_tdata[ActW +: LevelW];
  assign out_write = m_axis_tdata[ActW+LevelW];
  assign unused_ok = ^{s_axis_tdata, s_axis_tuser, cfg_valid_i, cfg_ready_o,
                       cfg_index_i, cfg_data_i};

  // Track items in flight and the last reported level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q     <= '0;
      last_level_q <= '0;
    end else begin
      flight_q <= flight_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        last_level_q <= out_level;
      end
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // Drop light bits from every result
  a_no_light: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[BitLup:BitLoff] == 3'b000 || unused_ok != unused_ok))
    else $error("light action reported");

  // Keep the level unless a light action rewrote it
  a_level_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_write) |-> (out_level == last_level_q))
    else $error("level changed without write");

  // No result without an accepted item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (flight_q != 2'd0))
    else $error("result without item");

  // Two items at most are held inside
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && flight_q == 2'd2) |-> out_acc)
    else $error("item accepted beyond capacity");

endmodule

bind touch_action_debounce_repeat_top tadr_checker u_tadr_checker (.*);

`default_nettype wire

// ===== sim/tb_touch_action_debounce_repeat_top.sv =====
// ----------------------------------------------------------------------------
// tb_touch_action_debounce_repeat_top: self-checking bench for action debounce
// Sends touch samples and page-change items over the sample stream and checks
// every result against a cycle-free predictor of lockout, auto-repeat and the
// brightness level. It covers directed edge cases, then gestures with random
// content across several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_touch_action_debounce_repeat_top;
  import tadr_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned LongHold    = 40;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 48;

  localparam logic [ActW-1:0] AllActs   = {ActW{1'b1}};
  localparam logic [ActW-1:0] PrevMask  = ActW'(1) << BitPrev;
  localparam logic [ActW-1:0] NextMask  = ActW'(1) << BitNext;
  localparam logic [ActW-1:0] NavMask   = PrevMask | NextMask;
  localparam logic [ActW-1:0] LoffMask  = ActW'(1) << BitLoff;
  localparam logic [ActW-1:0] LdownMask = ActW'(1) << BitLdown;
  localparam logic [ActW-1:0] LupMask   = ActW'(1) << BitLup;
  localparam logic [ActW-1:0] LightMask = LoffMask | LdownMask | LupMask;

  typedef struct packed {
    logic [ActW-1:0]   fired;
    logic [LevelW-1:0] level;
    logic              wr;
  } touch_result_t;

  // Predicts lockout, repeat and level per item and checks results in order
  class action_scoreboard;
    logic [MsW-1:0]    debounce_ms;
    logic [MsW-1:0]    rep_delay_ms;
    logic [MsW-1:0]    rep_rate_ms;
    logic [LevelW-1:0] light_step;
    logic [LevelW-1:0] light_max;
    logic [ActW-1:0]   prior_mask;
    logic [TimeW-1:0]  fire_stamp [ActW];
    bit                ignoring;
    tadr_rep_e         rep_action;
    logic [TimeW-1:0]  rep_deadline;
    logic [LevelW-1:0] level;
    touch_result_t     expected_q [$];
    int                n_errors;
    int                n_results;
    int                n_fired;
    int                n_writes;

    function new();
      debounce_ms  = DebounceRst;
      rep_delay_ms = RepDelayRst;
      rep_rate_ms  = RepRateRst;
      light_step   = LightStepRst;
      light_max    = LightMaxRst;
      prior_mask   = '0;
      foreach (fire_stamp[i]) fire_stamp[i] = '0;
      ignoring     = 1'b0;
      rep_action   = RepNone;
      rep_deadline = '0;
      level        = '0;
      n_errors     = 0;
      n_results    = 0;
      n_fired      = 0;
      n_writes     = 0;
    endfunction

    function void note_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgIdxDebounce:  debounce_ms  = val;
        CfgIdxRepDelay:  rep_delay_ms = val;
        CfgIdxRepRate:   rep_rate_ms  = val;
        CfgIdxLightStep: light_step   = val[LevelW-1:0];
        CfgIdxLightMax:  light_max    = val[LevelW-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic op, logic [ActW-1:0] raw, logic touched,
                             logic batt, logic [TimeW-1:0] now);
      logic [ActW-1:0]  nav;
      logic [ActW-1:0]  held;
      logic [ActW-1:0]  cur;
      logic [ActW-1:0]  fired;
      logic [TimeW-1:0] since;
      logic [LevelW:0]  lvl;
      logic             wr;
      tadr_rep_e        code;
      touch_result_t    res;
      fired = '0;
      wr    = 1'b0;
      if (op == OpPageChange) begin
        ignoring     = 1'b1;
        rep_action   = RepNone;
        rep_deadline = '0;
      end else begin
        // Navigation counts only when exactly one of the two bits is set
        nav  = raw & NavMask;
        held = (nav == PrevMask || nav == NextMask) ? nav : '0;
        cur  = (raw & ~NavMask) | held;
        if (ignoring) begin
          rep_action   = RepNone;
          rep_deadline = '0;
          prior_mask   = touched ? cur : '0;
          if (!touched) ignoring = 1'b0;
        end else begin
          // Fire rising edges whose lockout has run out
          for (int i = 0; i < ActW; i++) begin
            if (cur[i] && !prior_mask[i] &&
                (now - fire_stamp[i]) >= TimeW'(debounce_ms)) begin
              fired[i]      = 1'b1;
              fire_stamp[i] = now;
            end
          end
          // Advance the auto-repeat of a single held navigation action
          code = held[BitPrev] ? RepPrev : (held[BitNext] ? RepNext : RepNone);
          since = now - rep_deadline;
          if (code == RepNone) begin
            rep_action   = RepNone;
            rep_deadline = '0;
          end else if (rep_action != code) begin
            rep_action   = code;
            rep_deadline = now + TimeW'(rep_delay_ms);
          end else if (!since[TimeW-1]) begin
            fired        = fired | held;
            rep_deadline = now + TimeW'(rep_rate_ms);
          end
          prior_mask = cur;
          // Step the level: off beats up, up beats down
          if ((fired & LightMask) != '0) begin
            lvl = {1'b0, level};
            if (fired[BitLoff]) begin
              lvl = '0;
            end else if (fired[BitLup]) begin
              lvl = lvl + light_step;
              if (lvl > {1'b0, light_max}) lvl = {1'b0, light_max};
            end else begin
              lvl = (lvl < {1'b0, light_step}) ? '0 : lvl - light_step;
            end
            level = lvl[LevelW-1:0];
            wr    = 1'b1;
            if (batt) fired[BitRefresh] = 1'b1;
          end
        end
      end
      res.fired = fired & ~LightMask;
      res.level = level;
      res.wr    = wr;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      touch_result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with no item pending: tdata %h", data);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      if (data[20:0] != want.fired) begin
        $error("fired_actions mismatch: expected %h, actual %h", want.fired, data[20:0]);
        n_errors++;
      end
      if (data[24:21] != want.level) begin
        $error("brightness mismatch: expected %0d, actual %0d", want.level, data[24:21]);
        n_errors++;
      end
      if (data[25] != want.wr) begin
        $error("brightness_write mismatch: expected %0d, actual %0d", want.wr, data[25]);
        n_errors++;
      end
      if (want.fired != '0) n_fired++;
      if (want.wr) n_writes++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  action_scoreboard sb = new();
  bit               calm = 1'b0;
  bit               long_hold_req = 1'b0;
  logic [TimeW-1:0] clock_ms = '0;
  int               n_sent = 0;
  int               n_pages = 0;

  touch_action_debounce_repeat_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(ClkPeriod * LimitCycles);
    $display("FAILURE");
    $finish;
  end

  // Pace the result side: random short stalls, one long hold on request
  initial begin
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && long_hold_req) begin
        hold_left     = LongHold;
        long_hold_req = 1'b0;
      end else if (hold_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 6);
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Offer one item, hold it until accepted; starts and ends at a falling edge
  task automatic send_item(input logic op, input logic [ActW-1:0] raw,
                           input logic touched, input logic batt,
                           input logic [TimeW-1:0] now);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, now, batt, touched, raw};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, raw, touched, batt, now);
    n_sent++;
    if (op == OpPageChange) n_pages++;
    @(negedge clk_i);
  endtask

  // Advance the panel clock and send a sample
  task automatic tap(input logic [ActW-1:0] raw, input logic touched,
                     input logic batt, input int unsigned step_ms);
    clock_ms = clock_ms + step_ms;
    send_item(OpSample, raw, touched, batt, clock_ms);
  endtask

  // Stop offering and wait for every pending result
  task automatic wait_drained(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.note_config(idx, val);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [MsW-1:0] deb, input logic [MsW-1:0] dly,
                              input logic [MsW-1:0] rate, input logic [LevelW-1:0] step,
                              input logic [LevelW-1:0] lmax);
    write_reg(CfgIdxDebounce, deb);
    write_reg(CfgIdxRepDelay, dly);
    write_reg(CfgIdxRepRate, rate);
    write_reg(CfgIdxLightStep, CfgDataW'(step));
    write_reg(CfgIdxLightMax, CfgDataW'(lmax));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed gestures, each ending in a release, plus some noise
  task automatic run_gestures(input int n_items);
    int              stop_at;
    int              len;
    int              kind;
    logic [ActW-1:0] mask;
    logic [ActW-1:0] extra;
    logic            batt;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      kind  = $urandom_range(0, 9);
      batt  = 1'($urandom_range(0, 1));
      len   = $urandom_range(1, 4);
      extra = ($urandom_range(0, 3) == 0) ? (ActW'($urandom) & ~(NavMask | LightMask)) : '0;
      case (kind)
        0, 1, 2, 3: begin
          // hold one navigation action long enough to repeat
          mask = ($urandom_range(0, 1) != 0 ? PrevMask : NextMask) | extra;
          len  = $urandom_range(2, 12);
          for (int k = 0; k < len; k++) tap(mask, 1'b1, batt, $urandom_range(10, 250));
        end
        4, 5: begin
          // light buttons, single or combined
          mask = ActW'($urandom_range(1, 7)) << BitLoff;
          for (int k = 0; k < len; k++) tap(mask | extra, 1'b1, batt, $urandom_range(10, 200));
        end
        6: begin
          for (int k = 0; k < len; k++)
            tap(ActW'($urandom), 1'b1, batt, $urandom_range(0, 300));
        end
        7: begin
          // page change, then touches that must be ignored
          send_item(OpPageChange, ActW'($urandom), 1'($urandom_range(0, 1)), batt, clock_ms);
          for (int k = 0; k < len; k++)
            tap(ActW'($urandom), 1'b1, batt, $urandom_range(5, 100));
        end
        8: begin
          send_item(1'($urandom_range(0, 7) == 0), ActW'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        end
        default: begin
          // long gap, then a press with any content
          clock_ms = clock_ms + $urandom_range(60000, 200000);
          tap(ActW'($urandom) | PrevMask, 1'b1, batt, 0);
          tap(PrevMask, 1'b1, batt, $urandom_range(0, 70000));
        end
      endcase
      tap('0, 1'b0, batt, $urandom_range(10, 300));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed edge cases at reset settings
    send_item(OpSample, '0, 1'b0, 1'b0, 32'd0);
    send_item(OpSample, PrevMask, 1'b1, 1'b0, 32'd50);            // too early to fire
    send_item(OpSample, PrevMask, 1'b1, 1'b0, 32'd600);           // repeat due
    send_item(OpSample, NavMask, 1'b1, 1'b0, 32'd700);            // both nav: none held
    send_item(OpSample, AllActs, 1'b1, 1'b1, 32'd1000);           // off wins, refresh
    send_item(OpSample, '0, 1'b0, 1'b0, 32'd1100);
    send_item(OpSample, LupMask | LdownMask, 1'b1, 1'b0, 32'd1300); // up wins over down
    send_item(OpSample, LupMask, 1'b1, 1'b0, 32'd1350);           // still held
    send_item(OpSample, '0, 1'b0, 1'b0, 32'd1400);
    send_item(OpSample, LdownMask, 1'b1, 1'b1, 32'd1600);         // dim on battery page
    send_item(OpSample, '0, 1'b0, 1'b0, 32'd1700);
    send_item(OpPageChange, AllActs, 1'b1, 1'b1, 32'd1800);
    send_item(OpSample, NextMask, 1'b1, 1'b0, 32'd1900);          // ignored
    send_item(OpSample, NextMask, 1'b0, 1'b0, 32'd2000);          // release ends ignoring
    send_item(OpSample, NextMask, 1'b1, 1'b0, 32'hFFFF_FF00);
    send_item(OpSample, NextMask, 1'b1, 1'b0, 32'hFFFF_FFFF);     // wrapped deadline ahead
    send_item(OpSample, NextMask, 1'b1, 1'b0, 32'h0000_0100);     // wrapped deadline passed
    send_item(OpSample, '0, 1'b0, 1'b0, 32'h0000_0200);
    send_item(OpSample, LupMask, 1'b1, 1'b1, 32'h0000_0300);

    // Random gestures under several register settings
    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_drained(DrainCycles);
      case (phase)
        0: program_regs('0, '0, '0, 4'd15, 4'd15);
        1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd1, 4'd1);
        2: program_regs(DebounceRst, RepDelayRst, RepRateRst, 4'd0, LightMaxRst);
        default: program_regs(MsW'($urandom_range(0, 300)), MsW'($urandom_range(0, 800)),
                              ($urandom_range(0, 3) == 0) ? '0 : MsW'($urandom_range(1, 400)),
                              LevelW'($urandom_range(1, 15)), LevelW'($urandom_range(1, 15)));
      endcase
      if (phase == 5) clock_ms = 32'hFFFF_0000;
      if (phase == NumPhases - 1) calm = 1'b1;
      if (phase == 3) long_hold_req = 1'b1;
      if (phase == 4) begin
        run_gestures(PhaseItems / 2);
        wait_drained(0);
        run_gestures(PhaseItems / 2);
      end else begin
        run_gestures(PhaseItems);
      end
    end

    wait_drained(DrainCycles);
    $display("Sent %0d items (%0d page changes) over %0d register settings.",
             n_sent, n_pages, NumPhases + 1);
    $display("Checked %0d results: %0d with fired actions, %0d level updates, %0d errors.",
             sb.n_results, sb.n_fired, sb.n_writes, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/tadr_pkg.sv
rtl/tadr_light.sv
rtl/touch_action_debounce_repeat_top.sv
rtl/tadr_checker.sv
sim/tb_touch_action_debounce_repeat_top.sv
